// ===== rtl/kmps_pkg.sv =====
// Shared types and constants of the k-mismatch pattern search block.
package kmps_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned PAT_CHARS   = 32;
  localparam int unsigned FIFO_DEPTH  = 2;
  localparam int unsigned APB_AW      = 6;
  localparam int unsigned APB_DW      = 64;
  localparam int unsigned PAT_WORDS   = 4;

  localparam logic [CHAR_W-1:0] HEADER_MARK = 8'h3E;

  // register indexes (byte address / 8)
  localparam logic [2:0] REG_PAT0 = 3'd0;
  localparam logic [2:0] REG_PAT1 = 3'd1;
  localparam logic [2:0] REG_PAT2 = 3'd2;
  localparam logic [2:0] REG_PAT3 = 3'd3;
  localparam logic [2:0] REG_LEN  = 3'd4;
  localparam logic [2:0] REG_MAXM = 3'd5;

  typedef logic [PAT_CHARS-1:0][CHAR_W-1:0] pattern_t;

  typedef struct packed {
    pattern_t          pattern;
    logic [CNT_W-1:0]  length;
    logic [CNT_W-1:0]  max_mis;
  } cfg_t;

  // classified text byte, front to back
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              line_end;
    logic              eof;
    logic              skip;
  } item_t;

  typedef struct packed {
    logic hit;
    logic found;
    logic done;
  } res_t;

endpackage

// ===== rtl/kmps_fifo.sv =====
// Small register queue used between the front, the back and the result port.
module kmps_fifo #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) count_d = count_q + CNT_W'(1);
    else if (!do_push && do_pop) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count above depth");

endmodule

// ===== rtl/kmps_front.sv =====
// Front end: takes text bytes and tags header lines before queuing them.
module kmps_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [7:0]            text_char_i,
  input  logic                  end_of_line_i,
  input  logic                  end_of_file_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output kmps_pkg::item_t       q_item_o
);
  import kmps_pkg::*;

  logic at_start_q, at_start_d;
  logic skip_q, skip_d;
  logic line_end, skip_now, take;

  assign take     = push_i && !q_full_i;
  assign line_end = end_of_line_i || end_of_file_i;
  assign skip_now = skip_q || (at_start_q && (text_char_i == HEADER_MARK));

  always_comb begin
    at_start_d = at_start_q;
    skip_d     = skip_q;
    if (take) begin
      at_start_d = line_end;
      skip_d     = line_end ? 1'b0 : skip_now;
    end
  end

  assign q_push_o          = take;
  assign q_item_o.ch       = text_char_i;
  assign q_item_o.line_end = line_end;
  assign q_item_o.eof      = end_of_file_i;
  assign q_item_o.skip     = skip_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      skip_q     <= 1'b0;
    end else begin
      at_start_q <= at_start_d;
      skip_q     <= skip_d;
    end
  end

endmodule

// ===== rtl/kmps_back.sv =====
// Back end: one cell per window age, updated in parallel for every text byte outside header lines.
module kmps_back #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kmps_pkg::cfg_t   cfg_i,
  input  logic             in_empty_i,
  input  kmps_pkg::item_t  in_item_i,
  output logic             in_pop_o,
  input  logic             out_full_i,
  output logic             out_push_o,
  output kmps_pkg::res_t   out_res_o
);
  import kmps_pkg::*;

  localparam logic [CNT_W-1:0] MaxLen = CNT_W'(MAX_PATTERN);

  logic [CNT_W-1:0] wc_q [MAX_PATTERN];
  logic [CNT_W-1:0] nc   [MAX_PATTERN];
  logic [CNT_W-1:0] cil_q, cil_d;
  logic             found_q, found_d;
  logic             fire, hit;
  logic [CNT_W-1:0] len_eff, len_m1, active, cil_p1;
  logic [MAX_PATTERN-1:0] cell_hit;

  assign fire = !in_empty_i && !out_full_i;

  always_comb begin
    if (cfg_i.length == '0) len_eff = CNT_W'(1);
    else if (cfg_i.length > MaxLen) len_eff = MaxLen;
    else len_eff = cfg_i.length;
  end

  assign len_m1 = len_eff - CNT_W'(1);
  assign cil_p1 = cil_q + CNT_W'(1);
  assign active = (cil_p1 > len_eff) ? len_eff : cil_p1;

  for (genvar a = 0; a < MAX_PATTERN; a++) begin : g_cell
    logic [CNT_W-1:0] prev;
    logic             in_act, is_last, mis;
    logic [CNT_W:0]   total;

    if (a == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = wc_q[a-1];
    end

    assign in_act  = (CNT_W'(a) < active);
    assign is_last = (CNT_W'(a) == len_m1);
    assign mis     = (in_item_i.ch != cfg_i.pattern[a]);
    assign nc[a]   = in_act ? prev + CNT_W'(mis) : wc_q[a];
    // overhang: pattern positions past the line end count once each
    assign total   = {1'b0, nc[a]} + {1'b0, len_m1 - CNT_W'(a)};
    assign cell_hit[a] =
      (is_last && (active == len_eff) && (nc[a] <= cfg_i.max_mis)) ||
      (!is_last && in_act && in_item_i.line_end && (total <= {1'b0, cfg_i.max_mis}));
  end

  assign hit = !in_item_i.skip && (|cell_hit);

  always_comb begin
    cil_d   = cil_q;
    found_d = found_q;
    if (fire) begin
      if (in_item_i.line_end) cil_d = '0;
      else if (!in_item_i.skip) cil_d = (cil_q == MaxLen) ? cil_q : cil_p1;
      found_d = in_item_i.eof ? 1'b0 : (found_q || hit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cil_q   <= '0;
      found_q <= 1'b0;
      for (int i = 0; i < MAX_PATTERN; i++) wc_q[i] <= '0;
    end else begin
      cil_q   <= cil_d;
      found_q <= found_d;
      if (fire) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
          if (in_item_i.line_end) wc_q[i] <= '0;
          else if (!in_item_i.skip) wc_q[i] <= nc[i];
        end
      end
    end
  end

  assign in_pop_o        = fire;
  assign out_push_o      = fire;
  assign out_res_o.hit   = hit;
  assign out_res_o.found = found_q || hit;
  assign out_res_o.done  = in_item_i.eof;

  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_item_i.eof) |=> !found_q)
    else $error("found flag not cleared after end of file");

  a_header_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_item_i.skip && !in_item_i.line_end) |=> $stable(cil_q))
    else $error("header byte changed line count");

  a_cil_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cil_q <= MaxLen)
    else $error("line count above pattern limit");

endmodule

// ===== rtl/k_mismatch_pattern_search_top.sv =====
// Top level of the k-mismatch pattern search block with its register port.
//
// Text bytes are pushed in one per transfer and each produces exactly one
// result transfer, in order. The block sustains one byte per clock cycle
// while the result queue is not full. A byte waits in the front queue
// until the back takes it; the back writes its result into the result
// queue, from which it shows on the result ports until it is popped. The
// per-byte work is one pass of MAX_PATTERN parallel window cells, each a
// byte compare, a 6-bit add and the limit compares, all combinational.
// The front tags header lines (first byte '>') and queues bytes; the back
// keeps one mismatch counter per window age and reports whether a window
// closed within max_mismatches, plus a sticky found bit that resets after
// the end-of-file byte (whose result still shows the final value).
// Registers sit at byte address 8*i: four 64-bit pattern words, the
// pattern length and the mismatch limit; write them only while idle.
module k_mismatch_pattern_search_top #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // text side
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    text_char_i,
  input  logic                          end_of_line_i,
  input  logic                          end_of_file_i,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic                          window_hit_o,
  output logic                          found_o,
  output logic                          search_done_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kmps_pkg::APB_AW-1:0]   paddr,
  input  logic [kmps_pkg::APB_DW-1:0]   pwdata,
  output logic [kmps_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import kmps_pkg::*;

  // configuration registers
  logic [PAT_WORDS-1:0][APB_DW-1:0] pat_q;
  logic [CNT_W-1:0]                 len_q, maxm_q;
  logic [2:0]                       reg_idx;
  logic                             cfg_wr;
  cfg_t                             cfg;

  // front queue and result queue wiring
  logic  mq_push, mq_full, mq_pop, mq_empty;
  item_t mq_wdata, mq_rdata;
  logic  rq_push, rq_full;
  res_t  rq_wdata, rq_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      len_q  <= CNT_W'(1);
      maxm_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_q[reg_idx[1:0]] <= pwdata;
        REG_LEN:  len_q  <= pwdata[CNT_W-1:0];
        REG_MAXM: maxm_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: prdata = pat_q[reg_idx[1:0]];
      REG_LEN:  prdata = {{(APB_DW-CNT_W){1'b0}}, len_q};
      REG_MAXM: prdata = {{(APB_DW-CNT_W){1'b0}}, maxm_q};
      default:  prdata = '0;
    endcase
  end

  // pattern char 0 is the low byte of word 0
  assign cfg.pattern = pat_q;
  assign cfg.length  = len_q;
  assign cfg.max_mis = maxm_q;

  kmps_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .text_char_i   (text_char_i),
    .end_of_line_i (end_of_line_i),
    .end_of_file_i (end_of_file_i),
    .q_full_i      (mq_full),
    .q_push_o      (mq_push),
    .q_item_o      (mq_wdata)
  );

  assign full = mq_full;

  kmps_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mq_push),
    .wdata_i (mq_wdata),
    .full_o  (mq_full),
    .pop_i   (mq_pop),
    .rdata_o (mq_rdata),
    .empty_o (mq_empty)
  );

  kmps_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_empty_i (mq_empty),
    .in_item_i  (mq_rdata),
    .in_pop_o   (mq_pop),
    .out_full_i (rq_full),
    .out_push_o (rq_push),
    .out_res_o  (rq_wdata)
  );

  kmps_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .wdata_i (rq_wdata),
    .full_o  (rq_full),
    .pop_i   (pop),
    .rdata_o (rq_rdata),
    .empty_o (empty)
  );

  assign window_hit_o  = rq_rdata.hit;
  assign found_o       = rq_rdata.found;
  assign search_done_o = rq_rdata.done;

endmodule
